// ===== rtl/can_signal_frame_packer_assert.svh =====
// ----------------------------------------------------------------------------
// can_signal_frame_packer_assert.svh
// Assertion macros for the frame packer datapath. A module that uses them
// must have clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_FRAME_PACKER_ASSERT_SVH
`define CAN_SIGNAL_FRAME_PACKER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define CSFP_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define CSFP_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/csfp_pkg.sv =====
// ----------------------------------------------------------------------------
// csfp_pkg
// Shared types and constants of the CAN signal frame packer: controller
// states, datapath command and status groups, and result status codes.
// ----------------------------------------------------------------------------
package csfp_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 64;

    localparam logic       OP_ENCODE = 1'b0;
    localparam logic       OP_EMIT   = 1'b1;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_BADLEN = 2'd1;
    localparam logic [1:0] STS_DROP   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ABS,
        ST_MUL,
        ST_RND,
        ST_SAT,
        ST_ALIGN_A,
        ST_ALIGN_B,
        ST_WR_FIRST,
        ST_WR,
        ST_RESULT,
        ST_EM_RD,
        ST_EM_LD
    } state_t;

    typedef struct packed {
        logic capture;
        logic diff;
        logic absval;
        logic mul;
        logic rnd;
        logic sat;
        logic align_a;
        logic align_b;
        logic rd_first;
        logic wr_step;
        logic em_rd;
        logic em_load;
        logic enc_load;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic is_emit;
        logic len_bad;
        logic mul_done;
        logic rng_cur;
        logic rng_next;
        logic em_last;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/csfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// csfp_ctrl
// Sequencer of the frame packer. Steps the datapath through capture,
// conversion, alignment, byte read-modify-write, result delivery and frame emit.
// ----------------------------------------------------------------------------
module csfp_ctrl
    import csfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.diff = 1'b1;
                if (sts.is_emit)
                begin
                    state_next = ST_EM_RD;
                end
                else if (sts.len_bad)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:
            begin
                cmd.absval = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (sts.mul_done)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = ST_ALIGN_A;
            end
            ST_ALIGN_A:
            begin
                cmd.align_a = 1'b1;
                state_next  = ST_ALIGN_B;
            end
            ST_ALIGN_B:
            begin
                cmd.align_b = 1'b1;
                state_next  = ST_WR_FIRST;
            end
            ST_WR_FIRST:
            begin
                if (sts.rng_cur)
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = ST_WR;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_WR:
            begin
                cmd.wr_step = 1'b1;
                if (!sts.rng_next)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.enc_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EM_RD:
            begin
                cmd.em_rd  = 1'b1;
                state_next = ST_EM_LD;
            end
            ST_EM_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.em_load = 1'b1;
                    if (sts.em_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/csfp_dp.sv =====
// ----------------------------------------------------------------------------
// csfp_dp
// Datapath of the frame packer: item capture, scaled conversion through a
// four-step 25x24 multiplier, saturation, bit alignment, the frame byte
// memory with per-byte valid flags, and the output register.
// ----------------------------------------------------------------------------
`include "can_signal_frame_packer_assert.svh"

module csfp_dp
    import csfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    input  logic        op,
    input  logic [8:0]  start_bit,
    input  logic [6:0]  bit_length,
    input  logic        little_endian,
    input  logic        is_signed,
    input  logic [47:0] phys_value,
    input  logic [47:0] offset,
    input  logic [47:0] scale_recip,
    input  logic [6:0]  frame_length,
    input  logic [28:0] message_id,
    input  logic [28:0] override_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  byte_index,
    output logic [7:0]  byte_value,
    output logic [28:0] frame_id,
    output logic [6:0]  out_length,
    output logic [1:0]  status,
    output logic        last
);

    localparam int         AW      = $clog2(MAX_FRAME_BYTES);
    localparam logic [6:0] MAX_LEN = 7'(MAX_FRAME_BYTES);

    function automatic logic [63:0] rev64(input logic [63:0] v);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++)
        begin
            r[i] = v[63 - i];
        end
        return r;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    // Captured item.
    logic        op_reg;
    logic [8:0]  start_reg;
    logic [6:0]  len_reg;
    logic        intel_reg;
    logic        sgn_reg;
    logic [47:0] phys_reg;
    logic [47:0] off_reg;
    logic [47:0] recip_reg;
    logic [6:0]  flen_reg;
    logic [6:0]  flen_next;
    logic [28:0] id_reg;
    logic [28:0] id_next;

    // Conversion.
    logic [48:0] diff_reg;
    logic [48:0] diff_next;
    logic [48:0] amag_reg;
    logic [48:0] amag_next;
    logic [47:0] bmag_reg;
    logic [47:0] bmag_next;
    logic        neg_reg;
    logic        rz_reg;
    logic [2:0]  mcnt_reg;
    logic [48:0] prod_reg;
    logic [48:0] prod_next;
    logic [1:0]  psh_reg;
    logic [96:0] acc_reg;
    logic [96:0] acc_next;
    logic [96:0] addend;
    logic [96:0] rsum;
    logic [48:0] mag_reg;
    logic [63:0] raw_reg;
    logic [63:0] raw_next;
    logic [63:0] msk_reg;
    logic [1:0]  sts_reg;

    // Alignment and byte loop.
    logic [63:0] src_reg;
    logic [63:0] src_next;
    logic [71:0] dwin_reg;
    logic [71:0] dwin_next;
    logic [71:0] mwin_reg;
    logic [71:0] mwin_next;
    logic [6:0]  cur_reg;
    logic [6:0]  cur_inc;
    logic [6:0]  last_byte_reg;
    logic [9:0]  last_pos;
    logic [2:0]  off3;

    // Saturation terms.
    logic [5:0]  lm1;
    logic [63:0] half;
    logic [63:0] top;
    logic [63:0] limit;
    logic [63:0] mag64;
    logic [63:0] msat;
    logic        neg_eff;
    logic [24:0] apart;
    logic [23:0] bpart;
    logic [6:0]  rsh;

    // Frame memory.
    logic [7:0]           mem_reg [MAX_FRAME_BYTES];
    logic [MAX_FRAME_BYTES-1:0] vld_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_vld_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic [7:0]           old_byte;
    logic [7:0]           dbyte;
    logic [7:0]           mbyte;

    // Emit.
    logic [5:0]  em_idx_reg;
    logic [5:0]  em_end;

    // Output register.
    logic        out_valid_reg;
    logic [5:0]  byte_index_reg;
    logic [7:0]  byte_value_reg;
    logic [28:0] frame_id_reg;
    logic [6:0]  out_length_reg;
    logic [1:0]  status_reg;
    logic        last_reg;

    assign flen_next = (frame_length > MAX_LEN) ? MAX_LEN : frame_length;
    assign id_next   = (override_id != 29'd0) ? override_id : message_id;

    assign diff_next = {phys_reg[47], phys_reg} - {off_reg[47], off_reg};
    assign amag_next = diff_reg[48] ? (49'd0 - diff_reg) : diff_reg;
    assign bmag_next = recip_reg[47] ? (48'd0 - recip_reg) : recip_reg;

    assign apart     = mcnt_reg[1] ? {1'b0, amag_reg[48:25]} : amag_reg[24:0];
    assign bpart     = mcnt_reg[0] ? bmag_reg[47:24] : bmag_reg[23:0];
    assign prod_next = {24'd0, apart} * {25'd0, bpart};

    always_comb
    begin
        case (psh_reg)
            2'd0:    addend = {48'd0, prod_reg};
            2'd1:    addend = {48'd0, prod_reg} << 24;
            2'd2:    addend = {48'd0, prod_reg} << 25;
            default: addend = {48'd0, prod_reg} << 49;
        endcase
    end

    assign acc_next = acc_reg + addend;
    assign rsum     = acc_reg + (97'd1 << 47);

    // Saturation to the range of the signal length.
    assign lm1     = 6'(len_reg - 7'd1);
    assign half    = 64'd1 << lm1;
    assign top     = (half << 1) - 64'd1;
    assign neg_eff = neg_reg && (mag_reg != 49'd0);
    assign mag64   = {15'd0, mag_reg};

    always_comb
    begin
        if (sgn_reg)
        begin
            limit = neg_eff ? half : (half - 64'd1);
        end
        else
        begin
            limit = top;
        end
        msat = (mag64 > limit) ? limit : mag64;
        if (rz_reg || (!sgn_reg && neg_eff))
        begin
            raw_next = 64'd0;
        end
        else if (sgn_reg && neg_eff)
        begin
            raw_next = 64'd0 - msat;
        end
        else
        begin
            raw_next = msat;
        end
    end

    // Motorola fields are handled in a bit-reversed byte space, so both orders
    // become a contiguous window starting at the byte of start_bit.
    assign rsh      = 7'd64 - len_reg;
    assign src_next = intel_reg ? raw_reg : (rev64(raw_reg) >> rsh);
    assign off3     = intel_reg ? start_reg[2:0] : ~start_reg[2:0];
    assign dwin_next = {8'd0, src_reg} << off3;
    assign mwin_next = {8'd0, msk_reg} << off3;
    assign last_pos = intel_reg
                    ? ({1'b0, start_reg} + {3'd0, len_reg} - 10'd1)
                    : ({1'b0, start_reg[8:3], ~start_reg[2:0]} + {3'd0, len_reg} - 10'd1);

    assign cur_inc = cur_reg + 7'd1;

    // Byte merge.
    assign old_byte = rd_vld_reg ? rd_data_reg : 8'd0;
    assign dbyte    = intel_reg ? dwin_reg[7:0] : rev8(dwin_reg[7:0]);
    assign mbyte    = intel_reg ? mwin_reg[7:0] : rev8(mwin_reg[7:0]);
    assign wr_data  = (old_byte & ~mbyte) | (dbyte & mbyte);
    assign wr_en    = cmd.wr_step;
    assign wr_addr  = cur_reg[AW-1:0];

    assign rd_en = cmd.rd_first || cmd.em_rd || (cmd.wr_step && sts.rng_next);

    always_comb
    begin
        if (cmd.em_rd)
        begin
            rd_addr = em_idx_reg[AW-1:0];
        end
        else if (cmd.wr_step)
        begin
            rd_addr = cur_inc[AW-1:0];
        end
        else
        begin
            rd_addr = cur_reg[AW-1:0];
        end
    end

    assign em_end = (flen_reg == 7'd0) ? 6'd0 : 6'(flen_reg - 7'd1);

    assign sts.is_emit  = (op_reg == OP_EMIT);
    assign sts.len_bad  = (len_reg == 7'd0) || (len_reg > 7'd64);
    assign sts.mul_done = (mcnt_reg == 3'd4);
    assign sts.rng_cur  = (cur_reg <= last_byte_reg) && (cur_reg < flen_reg);
    assign sts.rng_next = (cur_inc <= last_byte_reg) && (cur_inc < flen_reg);
    assign sts.em_last  = (em_idx_reg == em_end);
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            mcnt_reg      <= 3'd0;
            em_idx_reg    <= 6'd0;
            cur_reg       <= 7'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (cmd.absval)
            begin
                mcnt_reg <= 3'd0;
            end
            else if (cmd.mul)
            begin
                mcnt_reg <= mcnt_reg + 3'd1;
            end
            if (cmd.capture)
            begin
                em_idx_reg <= 6'd0;
            end
            else if (cmd.em_load)
            begin
                em_idx_reg <= em_idx_reg + 6'd1;
            end
            if (cmd.align_b)
            begin
                cur_reg <= {1'b0, start_reg[8:3]};
            end
            else if (cmd.wr_step && sts.rng_next)
            begin
                cur_reg <= cur_inc;
            end
            if (cmd.enc_load || cmd.em_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            start_reg <= start_bit;
            len_reg   <= bit_length;
            intel_reg <= little_endian;
            sgn_reg   <= is_signed;
            phys_reg  <= phys_value;
            off_reg   <= offset;
            recip_reg <= scale_recip;
            flen_reg  <= flen_next;
            id_reg    <= id_next;
        end
        if (cmd.diff)
        begin
            diff_reg <= diff_next;
            sts_reg  <= sts.len_bad ? STS_BADLEN : STS_OK;
        end
        if (cmd.absval)
        begin
            amag_reg <= amag_next;
            bmag_reg <= bmag_next;
            neg_reg  <= diff_reg[48] ^ recip_reg[47];
            rz_reg   <= (recip_reg == 48'd0);
            acc_reg  <= '0;
        end
        if (cmd.mul)
        begin
            if (!mcnt_reg[2])
            begin
                prod_reg <= prod_next;
                psh_reg  <= mcnt_reg[1:0];
            end
            if (mcnt_reg != 3'd0)
            begin
                acc_reg <= acc_next;
            end
        end
        if (cmd.rnd)
        begin
            mag_reg <= rsum[96:48];
        end
        if (cmd.sat)
        begin
            raw_reg <= raw_next;
            msk_reg <= top;
        end
        if (cmd.align_a)
        begin
            src_reg <= src_next;
        end
        if (cmd.align_b)
        begin
            dwin_reg      <= dwin_next;
            mwin_reg      <= mwin_next;
            last_byte_reg <= last_pos[9:3];
            if (last_pos[9:3] >= flen_reg)
            begin
                sts_reg <= STS_DROP;
            end
        end
        else if (cmd.wr_step)
        begin
            dwin_reg <= dwin_reg >> 8;
            mwin_reg <= mwin_reg >> 8;
        end
        if (cmd.enc_load)
        begin
            byte_index_reg <= 6'd0;
            byte_value_reg <= 8'd0;
            frame_id_reg   <= 29'd0;
            out_length_reg <= 7'd0;
            status_reg     <= sts_reg;
            last_reg       <= 1'b1;
        end
        else if (cmd.em_load)
        begin
            byte_index_reg <= em_idx_reg;
            byte_value_reg <= (flen_reg == 7'd0) ? 8'd0 : old_byte;
            frame_id_reg   <= id_reg;
            out_length_reg <= flen_reg;
            status_reg     <= STS_OK;
            last_reg       <= sts.em_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_index = byte_index_reg;
    assign byte_value = byte_value_reg;
    assign frame_id   = frame_id_reg;
    assign out_length = out_length_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    `CSFP_ASSERT_NOW(a_wr_in_frame, wr_en, cur_reg < flen_reg, "frame write beyond frame length")
    `CSFP_ASSERT_NEXT(a_clear_all, cmd.clear, vld_reg == '0, "frame store not cleared after emit")
    `CSFP_ASSERT_NOW(a_no_overwrite, out_valid_reg && out_stall, !(cmd.enc_load || cmd.em_load), "stalled result overwritten")

endmodule

// ===== rtl/can_signal_frame_packer.sv =====
// ----------------------------------------------------------------------------
// can_signal_frame_packer
// Packs scaled, saturated signals into a CAN data frame held in a byte
// memory, and emits the frame one byte per result beat.
//
//   Channel  Handshake              Beat contents
//   in       in_valid / in_stall    op start_bit bit_length little_endian is_signed
//                                   phys_value offset scale_recip frame_length
//                                   message_id override_id
//   out      out_valid / out_stall  byte_index byte_value frame_id out_length
//                                   status last
//
// An encode passes from acceptance through capture, decode, the four-step
// 25x24 multiplier, rounding, saturation, alignment and one read-modify-write
// per frame byte touched (0 to 9 bytes) on the frame memory before its result.
// A bad bit_length goes from decode straight to its result. An emit reads
// and loads each frame byte in turn. Reset clears the per-byte valid flags at
// once, so the frame reads as zero with no clearing pass. One result waits in the
// output register while the next input beat is taken; an emit holds at each
// byte while out_stall is high.
// ----------------------------------------------------------------------------
module can_signal_frame_packer
    import csfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [8:0]  start_bit,
    input  logic [6:0]  bit_length,
    input  logic        little_endian,
    input  logic        is_signed,
    input  logic [47:0] phys_value,
    input  logic [47:0] offset,
    input  logic [47:0] scale_recip,
    input  logic [6:0]  frame_length,
    input  logic [28:0] message_id,
    input  logic [28:0] override_id,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  byte_index,
    output logic [7:0]  byte_value,
    output logic [28:0] frame_id,
    output logic [6:0]  out_length,
    output logic [1:0]  status,
    output logic        last
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    csfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    csfp_dp #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .start_bit     (start_bit),
        .bit_length    (bit_length),
        .little_endian (little_endian),
        .is_signed     (is_signed),
        .phys_value    (phys_value),
        .offset        (offset),
        .scale_recip   (scale_recip),
        .frame_length  (frame_length),
        .message_id    (message_id),
        .override_id   (override_id),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .byte_index    (byte_index),
        .byte_value    (byte_value),
        .frame_id      (frame_id),
        .out_length    (out_length),
        .status        (status),
        .last          (last)
    );

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: regression bench for the CAN signal frame packer
// Drives directed and random encode and emit beats through the input channel,
// predicts every result beat from its own bit-level model of the frame store,
// and checks each accepted output beat against the oldest expected beat. The
// sender and the receiver idle at random in three phases of differing load.
// ----------------------------------------------------------------------------
module tb_top;
    import csfp_pkg::*;

    localparam logic [47:0] ONE_Q16 = 48'h0000_0001_0000;
    localparam logic [47:0] ONE_Q32 = 48'h0001_0000_0000;
    localparam logic [47:0] MAX_48  = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] MIN_48  = 48'h8000_0000_0000;

    typedef struct packed {
        logic        op;
        logic [8:0]  start_bit;
        logic [6:0]  bit_length;
        logic        little_endian;
        logic        is_signed;
        logic [47:0] phys_value;
        logic [47:0] offset;
        logic [47:0] scale_recip;
        logic [6:0]  frame_length;
        logic [28:0] message_id;
        logic [28:0] override_id;
    } signal_beat_t;

    typedef struct packed {
        logic [5:0]  byte_index;
        logic [7:0]  byte_value;
        logic [28:0] frame_id;
        logic [6:0]  out_length;
        logic [1:0]  status;
        logic        last;
    } byte_beat_t;

    class frame_checker;
        logic [7:0] frame_image [DEF_MAX_FRAME_BYTES];
        byte_beat_t pending_bytes [$];
        int errors;

        function new();
            foreach (frame_image[i]) frame_image[i] = 8'h00;
            errors = 0;
        endfunction

        function logic [63:0] scaled_raw(logic [47:0] phys, logic [47:0] off,
                                         logic [47:0] recip, int len, logic sgn);
            logic [48:0]  diff;
            logic [48:0]  dmag;
            logic [47:0]  rmag;
            logic [127:0] prod;
            logic [63:0]  mag;
            logic [63:0]  lim;
            logic         neg;
            if (recip == 48'd0)
                return 64'd0;
            diff = {phys[47], phys} - {off[47], off};
            dmag = diff[48] ? (~diff + 49'd1) : diff;
            rmag = recip[47] ? (~recip + 48'd1) : recip;
            neg = diff[48] ^ recip[47];
            prod = {79'd0, dmag} * {80'd0, rmag};
            prod = prod + (128'd1 << 47);
            mag = prod[111:48];
            if (mag == 64'd0)
                neg = 1'b0;
            if (sgn) begin
                lim = 64'd1 << (len - 1);
                if (neg) begin
                    if (mag > lim)
                        mag = lim;
                end
                else if (mag > lim - 64'd1) begin
                    mag = lim - 64'd1;
                end
            end
            else begin
                lim = (len >= 64) ? {64{1'b1}} : ((64'd1 << len) - 64'd1);
                if (neg) begin
                    mag = 64'd0;
                    neg = 1'b0;
                end
                if (mag > lim)
                    mag = lim;
            end
            return neg ? (64'd0 - mag) : mag;
        endfunction

        function logic [1:0] write_signal_bits(logic [63:0] raw, int start, int len,
                                               logic intel, int flen);
            int i;
            int pos;
            int byt;
            int bt;
            if (intel) begin
                for (i = 0; i < len; i++) begin
                    pos = start + i;
                    if (pos / 8 >= flen)
                        return STS_DROP;
                    frame_image[pos / 8][pos % 8] = raw[i];
                end
            end
            else begin
                byt = start / 8;
                bt = start % 8;
                for (i = len; i > 0; i--) begin
                    if (byt >= flen)
                        return STS_DROP;
                    frame_image[byt][bt] = raw[i - 1];
                    if (bt == 0) begin
                        byt++;
                        bt = 7;
                    end
                    else begin
                        bt--;
                    end
                end
            end
            return STS_OK;
        endfunction

        function void take_signal_beat(signal_beat_t b);
            byte_beat_t r;
            int flen;
            int n;
            int i;
            logic [63:0] raw;
            flen = (b.frame_length > DEF_MAX_FRAME_BYTES) ? DEF_MAX_FRAME_BYTES
                                                          : int'(b.frame_length);
            if (b.op == OP_EMIT) begin
                n = (flen != 0) ? flen : 1;
                for (i = 0; i < n; i++) begin
                    r.byte_index = 6'(i);
                    r.byte_value = (flen != 0) ? frame_image[i] : 8'h00;
                    r.frame_id = (b.override_id != 29'd0) ? b.override_id : b.message_id;
                    r.out_length = 7'(flen);
                    r.status = STS_OK;
                    r.last = (i + 1 == n);
                    pending_bytes.push_back(r);
                end
                foreach (frame_image[j]) frame_image[j] = 8'h00;
                return;
            end
            r = '0;
            r.last = 1'b1;
            if (b.bit_length == 7'd0 || b.bit_length > 7'd64) begin
                r.status = STS_BADLEN;
            end
            else begin
                raw = scaled_raw(b.phys_value, b.offset, b.scale_recip,
                                 int'(b.bit_length), b.is_signed);
                r.status = write_signal_bits(raw, int'(b.start_bit), int'(b.bit_length),
                                             b.little_endian, flen);
            end
            pending_bytes.push_back(r);
        endfunction

        function void report_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_byte_beat(byte_beat_t got);
            byte_beat_t want;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected result, expected none actual index %0d value 0x%0h status %0d",
                         $time, got.byte_index, got.byte_value, got.status);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            report_field("byte_index", 64'(want.byte_index), 64'(got.byte_index));
            report_field("byte_value", 64'(want.byte_value), 64'(got.byte_value));
            report_field("frame_id", 64'(want.frame_id), 64'(got.frame_id));
            report_field("out_length", 64'(want.out_length), 64'(got.out_length));
            report_field("status", 64'(want.status), 64'(got.status));
            report_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = OP_ENCODE;
    logic [8:0]  start_bit = '0;
    logic [6:0]  bit_length = '0;
    logic        little_endian = 1'b0;
    logic        is_signed = 1'b0;
    logic [47:0] phys_value = '0;
    logic [47:0] offset = '0;
    logic [47:0] scale_recip = '0;
    logic [6:0]  frame_length = '0;
    logic [28:0] message_id = '0;
    logic [28:0] override_id = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [5:0]  byte_index;
    logic [7:0]  byte_value;
    logic [28:0] frame_id;
    logic [6:0]  out_length;
    logic [1:0]  status;
    logic        last;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    frame_checker chk = new();

    can_signal_frame_packer dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                chk.take_signal_beat({op, start_bit, bit_length, little_endian, is_signed,
                                      phys_value, offset, scale_recip, frame_length,
                                      message_id, override_id});
            if (out_valid && !out_stall)
                chk.check_byte_beat({byte_index, byte_value, frame_id, out_length,
                                     status, last});
        end
    end

    initial
    begin
        #16_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function logic [47:0] q16(int v);
        logic [47:0] w;
        w = 48'(v);
        return w << 16;
    endfunction

    function logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function logic [47:0] rand_signed(int bits);
        logic signed [63:0] w;
        w = {$urandom, $urandom};
        w = w >>> (64 - bits);
        return w[47:0];
    endfunction

    function signal_beat_t encode_beat(int start, int len, logic intel, logic sgn,
                                       logic [47:0] phys, logic [47:0] off,
                                       logic [47:0] recip, int flen);
        signal_beat_t b;
        b = '0;
        b.op = OP_ENCODE;
        b.start_bit = 9'(start);
        b.bit_length = 7'(len);
        b.little_endian = intel;
        b.is_signed = sgn;
        b.phys_value = phys;
        b.offset = off;
        b.scale_recip = recip;
        b.frame_length = 7'(flen);
        return b;
    endfunction

    function signal_beat_t emit_beat(int flen, logic [28:0] mid, logic [28:0] ovr);
        signal_beat_t b;
        b = '0;
        b.op = OP_EMIT;
        b.frame_length = 7'(flen);
        b.message_id = mid;
        b.override_id = ovr;
        return b;
    endfunction

    function signal_beat_t random_encode(int flen);
        signal_beat_t b;
        int f;
        int r;
        f = (flen > DEF_MAX_FRAME_BYTES) ? DEF_MAX_FRAME_BYTES : flen;
        b.op = OP_ENCODE;
        if (f != 0 && $urandom_range(0, 9) < 8)
            b.start_bit = 9'($urandom_range(0, f * 8 - 1));
        else
            b.start_bit = 9'($urandom_range(0, 511));
        r = $urandom_range(0, 99);
        if (r < 45)
            b.bit_length = 7'($urandom_range(1, 16));
        else if (r < 88)
            b.bit_length = 7'($urandom_range(17, 64));
        else if (r < 94)
            b.bit_length = 7'd0;
        else
            b.bit_length = 7'($urandom_range(65, 127));
        b.little_endian = 1'($urandom_range(0, 1));
        b.is_signed = 1'($urandom_range(0, 1));
        b.phys_value = ($urandom_range(0, 1) == 0) ? rand_signed(25) : rand48();
        r = $urandom_range(0, 9);
        b.offset = (r < 4) ? 48'd0 : (r < 7) ? rand_signed(22) : rand48();
        r = $urandom_range(0, 9);
        if (r < 3)
            b.scale_recip = ONE_Q32;
        else if (r < 6)
            b.scale_recip = rand_signed(36);
        else if (r < 7)
            b.scale_recip = 48'd0;
        else
            b.scale_recip = rand48();
        b.frame_length = 7'(flen);
        b.message_id = 29'($urandom);
        b.override_id = ($urandom_range(0, 1) == 0) ? 29'd0 : 29'($urandom);
        return b;
    endfunction

    function int pick_frame_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8;
        else if (r < 6)
            return 64;
        else if (r < 8)
            return $urandom_range(1, 64);
        else if (r < 9)
            return $urandom_range(65, 127);
        return 0;
    endfunction

    task send_beat(input signal_beat_t b);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        op <= b.op;
        start_bit <= b.start_bit;
        bit_length <= b.bit_length;
        little_endian <= b.little_endian;
        is_signed <= b.is_signed;
        phys_value <= b.phys_value;
        offset <= b.offset;
        scale_recip <= b.scale_recip;
        frame_length <= b.frame_length;
        message_id <= b.message_id;
        override_id <= b.override_id;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task send_random_frames(input int count);
        int sent;
        int flen;
        signal_beat_t b;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 85) begin
                flen = pick_frame_len();
                repeat ($urandom_range(1, 6)) begin
                    send_beat(random_encode(flen));
                    sent++;
                end
                b = random_encode(flen);
                b.op = OP_EMIT;
                send_beat(b);
                sent++;
            end
            else begin
                b = random_encode($urandom_range(0, 127));
                if ($urandom_range(0, 2) == 0)
                    b.op = OP_EMIT;
                send_beat(b);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 22;
        receiver_stall_pct = 84;

        send_beat(emit_beat(8, 29'h123, 29'd0));
        send_beat(encode_beat(0, 8, 1'b1, 1'b0, q16(18), 48'd0, ONE_Q32, 8));
        send_beat(encode_beat(15, 16, 1'b0, 1'b1, q16(-300), 48'd0, ONE_Q32, 8));
        send_beat(encode_beat(32, 4, 1'b1, 1'b0, q16(2) + (ONE_Q16 >> 1), 48'd0,
                              ONE_Q32, 8));
        send_beat(encode_beat(36, 4, 1'b1, 1'b1, q16(-3) + (ONE_Q16 >> 1), 48'd0,
                              ONE_Q32, 8));
        send_beat(encode_beat(40, 4, 1'b1, 1'b1, q16(1000), 48'd0, ONE_Q32, 8));
        send_beat(encode_beat(44, 4, 1'b1, 1'b1, q16(-1000), 48'd0, ONE_Q32, 8));
        send_beat(encode_beat(48, 4, 1'b1, 1'b0, q16(-5), 48'd0, ONE_Q32, 8));
        send_beat(encode_beat(52, 4, 1'b1, 1'b0, q16(100), q16(-20), ONE_Q32, 8));
        send_beat(encode_beat(0, 0, 1'b1, 1'b0, q16(1), 48'd0, ONE_Q32, 8));
        send_beat(encode_beat(0, 65, 1'b0, 1'b1, q16(1), 48'd0, ONE_Q32, 8));
        send_beat(encode_beat(0, 127, 1'b1, 1'b1, q16(1), 48'd0, ONE_Q32, 8));
        send_beat(encode_beat(60, 8, 1'b1, 1'b0, q16(255), 48'd0, ONE_Q32, 8));
        send_beat(encode_beat(63, 16, 1'b0, 1'b0, q16(43981), 48'd0, ONE_Q32, 8));
        send_beat(encode_beat(8, 8, 1'b1, 1'b0, q16(77), 48'd0, 48'd0, 8));
        send_beat(emit_beat(8, 29'h1FFF_FFFF, 29'h00A_BCDE));
        send_beat(encode_beat(0, 64, 1'b1, 1'b1, MAX_48, MIN_48, MAX_48, 64));
        send_beat(encode_beat(200, 64, 1'b0, 1'b1, MIN_48, MAX_48, MIN_48, 64));
        send_beat(encode_beat(100, 64, 1'b1, 1'b0, MAX_48, MIN_48, MIN_48, 64));
        send_beat(encode_beat(511, 64, 1'b1, 1'b0, MAX_48, 48'd0, MAX_48, 127));
        send_beat(encode_beat(511, 64, 1'b0, 1'b1, q16(-1), 48'd0, ONE_Q32, 127));
        send_beat(encode_beat(24, 1, 1'b1, 1'b1, q16(1), 48'd0, ONE_Q32, 64));
        send_beat(emit_beat(127, 29'h0, 29'h1FFF_FFFF));
        send_beat(emit_beat(0, 29'h5, 29'd0));
        send_beat(emit_beat(64, 29'h1555_5555, 29'd0));

        send_random_frames(110);

        sender_idle_pct = 84;
        receiver_stall_pct = 22;
        send_random_frames(110);

        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_random_frames(110);

        in_valid <= 1'b0;
        while (chk.pending_bytes.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (chk.errors == 0 && chk.pending_bytes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
